// ----- rtl/stq_pkg.sv -----
package stq_pkg;

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_POP     = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_CANCEL  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic     load;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic       done;
      status_type status;
   } stat_type;

endpackage

// ----- rtl/sorted_timer_event_queue_core.sv -----
// Channel  Ports        Beat contents
// req      req_t*       tuser: kind[1:0]; tdata: event_tag, event_time
// rsp      rsp_t*       tdata: status[1:0], removed_tag, removed_time, entry_count,
//                              top_valid, top_tag, top_time
// The result is offered from the HOLD state, after the datapath update in the EXEC state.
// With rsp_tready held high a new request beat is taken once the controller has passed
// through accept, datapath update and result handshake.
// The slot compare and shift across all entries is combinational in the datapath.
// Reset is synchronous and empties the queue.
// A new beat is taken only after the previous result has been delivered.
module sorted_timer_event_queue_core #(
   parameter int DEPTH     = 16,
   parameter int TAG_BITS  = 8,
   parameter int TIME_BITS = 32,
   localparam int CNT_BITS  = $clog2(DEPTH + 1),
   localparam int IN_BITS   = TAG_BITS + TIME_BITS,
   localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS  = 2 + 2 * TAG_BITS + 2 * TIME_BITS + CNT_BITS + 1,
   localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_tuser,   // kind
   input  logic [IN_W-1:0]  req_tdata,   // event_tag, event_time
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata    // status, removed_tag, removed_time,
                                         // entry_count, top_valid, top_tag, top_time
);

   stq_pkg::cmd_type  cmd;
   stq_pkg::stat_type stat;
   logic [TAG_BITS-1:0]  removed_tag, top_tag;
   logic [TIME_BITS-1:0] removed_time, top_time;
   logic [CNT_BITS-1:0]  entry_count;
   logic                 top_valid;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   stq_datapath #(
      .DEPTH     (DEPTH),
      .TAG_BITS  (TAG_BITS),
      .TIME_BITS (TIME_BITS),
      .CNT_BITS  (CNT_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .in_tag       (req_tdata[0 +: TAG_BITS]),
      .in_time      (req_tdata[TAG_BITS +: TIME_BITS]),
      .stat         (stat),
      .removed_tag  (removed_tag),
      .removed_time (removed_time),
      .entry_count  (entry_count),
      .top_valid    (top_valid),
      .top_tag      (top_tag),
      .top_time     (top_time)
   );

   assign rsp_tdata = OUT_W'({top_time, top_tag, top_valid, entry_count,
                              removed_time, removed_tag, stat.status});

endmodule

// ----- rtl/stq_datapath.sv -----
module stq_datapath #(
   parameter int DEPTH     = 16,
   parameter int TAG_BITS  = 8,
   parameter int TIME_BITS = 32,
   parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stq_pkg::cmd_type      cmd,
   input  logic [TAG_BITS-1:0]   in_tag,
   input  logic [TIME_BITS-1:0]  in_time,
   output stq_pkg::stat_type     stat,
   output logic [TAG_BITS-1:0]   removed_tag,
   output logic [TIME_BITS-1:0]  removed_time,
   output logic [CNT_BITS-1:0]   entry_count,
   output logic                  top_valid,
   output logic [TAG_BITS-1:0]   top_tag,
   output logic [TIME_BITS-1:0]  top_time
);

   logic [TIME_BITS-1:0] time_ff [DEPTH];
   logic [TAG_BITS-1:0]  tag_ff  [DEPTH];
   logic [CNT_BITS-1:0]  count_ff, count_in;

   logic                  pend_ff;
   stq_pkg::kind_type     kind_ff;
   logic [TAG_BITS-1:0]   tag_op_ff;
   logic [TIME_BITS-1:0]  time_op_ff;
   stq_pkg::status_type   status_ff;

   logic [DEPTH-1:0] occ, gt_new, lt_new, hit, before_hit;
   logic [TIME_BITS-1:0] time_in [DEPTH];
   logic [TAG_BITS-1:0]  tag_in  [DEPTH];
   logic [TAG_BITS-1:0]  mtag;
   logic [TIME_BITS-1:0] mtime;
   logic                 found, later;
   stq_pkg::status_type  status_in;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occ[i]    = CNT_BITS'(i) < count_ff;
         gt_new[i] = occ[i] && (time_ff[i] > time_op_ff);
         lt_new[i] = occ[i] && (time_ff[i] < time_op_ff);
         hit[i]    = occ[i] && (tag_ff[i] == tag_op_ff);
      end
      before_hit[0] = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
         before_hit[i] = before_hit[i-1] && !hit[i-1];
      end
      found = |hit;
      mtag  = '0;
      mtime = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit[i] && before_hit[i]) begin
            mtag  = tag_ff[i];
            mtime = time_ff[i];
         end
      end
      later = !(time_op_ff < mtime);
   end

   always_comb begin
      status_in = stq_pkg::STATUS_OK;
      count_in  = count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         time_in[i] = time_ff[i];
         tag_in[i]  = tag_ff[i];
      end
      unique case (kind_ff)
         stq_pkg::KIND_INSERT: begin
            if (count_ff >= CNT_BITS'(DEPTH)) begin
               status_in = stq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               for (int i = 0; i < DEPTH; i++) begin
                  if (i > 0 && gt_new[(i+DEPTH-1)%DEPTH]) begin
                     time_in[i] = time_ff[(i+DEPTH-1)%DEPTH];
                     tag_in[i]  = tag_ff[(i+DEPTH-1)%DEPTH];
                  end else if (!occ[i] || gt_new[i]) begin
                     time_in[i] = time_op_ff;
                     tag_in[i]  = tag_op_ff;
                  end
               end
            end
         end
         stq_pkg::KIND_POP: begin
            if (count_ff == '0) begin
               status_in = stq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               for (int i = 0; i + 1 < DEPTH; i++) begin
                  time_in[i] = time_ff[i+1];
                  tag_in[i]  = tag_ff[i+1];
               end
            end
         end
         stq_pkg::KIND_CANCEL: begin
            if (!found) begin
               status_in = stq_pkg::STATUS_NOT_FOUND;
            end else begin
               count_in = count_ff - 1'b1;
               for (int i = 0; i + 1 < DEPTH; i++) begin
                  if (!before_hit[i] || hit[i]) begin
                     time_in[i] = time_ff[i+1];
                     tag_in[i]  = tag_ff[i+1];
                  end
               end
            end
         end
         stq_pkg::KIND_RESTART: begin
            if (!found) begin
               status_in = stq_pkg::STATUS_NOT_FOUND;
            end else if (later) begin
               // Entries after the hit with a smaller time move one slot forward.
               for (int i = 0; i < DEPTH; i++) begin
                  if (!before_hit[i] || (hit[i] && before_hit[i])) begin
                     if (i + 1 < DEPTH && !before_hit[(i+1)%DEPTH] && lt_new[(i+1)%DEPTH]) begin
                        time_in[i] = time_ff[(i+1)%DEPTH];
                        tag_in[i]  = tag_ff[(i+1)%DEPTH];
                     end else if ((hit[i] && before_hit[i]) || lt_new[i]) begin
                        time_in[i] = time_op_ff;
                        tag_in[i]  = mtag;
                     end
                  end
               end
            end else begin
               // Entries before the hit with a greater time move one slot back.
               for (int i = 0; i < DEPTH; i++) begin
                  if (before_hit[i]) begin
                     if (i > 0 && gt_new[(i+DEPTH-1)%DEPTH]) begin
                        time_in[i] = time_ff[(i+DEPTH-1)%DEPTH];
                        tag_in[i]  = tag_ff[(i+DEPTH-1)%DEPTH];
                     end else if (gt_new[i] || hit[i]) begin
                        time_in[i] = time_op_ff;
                        tag_in[i]  = mtag;
                     end
                  end
               end
            end
         end
         default: begin
            status_in = stq_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= cmd.load;
         if (pend_ff) begin
            count_ff <= count_in;
         end
      end
      if (cmd.load) begin
         kind_ff    <= cmd.kind;
         tag_op_ff  <= in_tag;
         time_op_ff <= in_time;
      end
      if (pend_ff) begin
         for (int i = 0; i < DEPTH; i++) begin
            time_ff[i] <= time_in[i];
            tag_ff[i]  <= tag_in[i];
         end
         status_ff    <= status_in;
         removed_tag  <= '0;
         removed_time <= '0;
         if (kind_ff == stq_pkg::KIND_POP && count_ff != '0) begin
            removed_tag  <= tag_ff[0];
            removed_time <= time_ff[0];
         end else if (kind_ff == stq_pkg::KIND_CANCEL && found) begin
            removed_tag  <= mtag;
            removed_time <= mtime;
         end
      end
   end

   assign stat.done   = pend_ff;
   assign stat.status = status_ff;
   assign entry_count = count_ff;
   assign top_valid   = count_ff != '0;
   assign top_tag     = top_valid ? tag_ff[0] : '0;
   assign top_time    = top_valid ? time_ff[0] : '0;

endmodule

// ----- rtl/stq_ctrl.sv -----
module stq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_kind,
   output logic              out_valid,
   input  logic              out_ready,
   output stq_pkg::cmd_type  cmd,
   input  stq_pkg::stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign in_ready  = state_ff == ST_IDLE;
   assign out_valid = valid_ff;
   assign cmd.load  = in_valid && in_ready;
   assign cmd.kind  = stq_pkg::kind_type'(in_kind);

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.done) begin
               state_in = ST_HOLD;
               valid_in = 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_ready) begin
               state_in = ST_IDLE;
               valid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- dv/tb.sv -----
module tb;
   import stq_pkg::*;

   localparam int DEPTH     = 16;
   localparam int TAG_BITS  = 8;
   localparam int TIME_BITS = 32;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int IN_W      = ((TAG_BITS + TIME_BITS + 7) / 8) * 8;
   localparam int OUT_BITS  = 2 + 2 * TAG_BITS + 2 * TIME_BITS + CNT_BITS + 1;
   localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
   localparam int N_RANDOM  = 600;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [TIME_BITS-1:0] top_time;
      logic [TAG_BITS-1:0]  top_tag;
      logic                 top_valid;
      logic [CNT_BITS-1:0]  entry_count;
      logic [TIME_BITS-1:0] removed_time;
      logic [TAG_BITS-1:0]  removed_tag;
      status_type           status;
   } result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [1:0]       req_tuser = '0;
   logic [IN_W-1:0]  req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;

   int  error_count = 0;
   int  cycle_count = 0;
   int  hold_cycles = 0;
   bit  long_hold_req = 1'b0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   class event_queue_scoreboard;
      logic [TIME_BITS-1:0] times[DEPTH];
      logic [TAG_BITS-1:0]  tags[DEPTH];
      int                   count;
      result_type           pending[$];
      int                   n_ops[4];
      int                   n_status[4];

      function void apply(kind_type kind, logic [TAG_BITS-1:0] tag,
                          logic [TIME_BITS-1:0] tim);
         result_type r;
         int i;
         int pos;
         logic [TAG_BITS-1:0] mtag;
         r = '0;
         r.status = STATUS_OK;
         pos = -1;
         n_ops[kind]++;
         if (kind == KIND_INSERT) begin
            if (count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               i = count;
               while (i > 0 && times[i-1] > tim) begin
                  times[i] = times[i-1];
                  tags[i]  = tags[i-1];
                  i--;
               end
               times[i] = tim;
               tags[i]  = tag;
               count++;
            end
         end else if (kind == KIND_POP) begin
            if (count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               pos = 0;
            end
         end else begin
            for (i = count - 1; i >= 0; i--)
               if (tags[i] == tag) pos = i;
            if (pos < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else if (kind == KIND_RESTART) begin
               mtag = tags[pos];
               i = pos;
               if (tim < times[pos]) begin
                  while (i > 0 && times[i-1] > tim) begin
                     times[i] = times[i-1];
                     tags[i]  = tags[i-1];
                     i--;
                  end
               end else begin
                  while (i + 1 < count && times[i+1] < tim) begin
                     times[i] = times[i+1];
                     tags[i]  = tags[i+1];
                     i++;
                  end
               end
               times[i] = tim;
               tags[i]  = mtag;
               pos = -1;
            end
         end
         if (pos >= 0) begin
            r.removed_tag  = tags[pos];
            r.removed_time = times[pos];
            for (i = pos; i + 1 < count; i++) begin
               times[i] = times[i+1];
               tags[i]  = tags[i+1];
            end
            count--;
         end
         r.entry_count = CNT_BITS'(count);
         if (count > 0) begin
            r.top_valid = 1'b1;
            r.top_tag   = tags[0];
            r.top_time  = times[0];
         end
         n_status[r.status]++;
         pending.push_back(r);
      endfunction

      task check(result_type got);
         result_type w;
         if (pending.size() == 0) begin
            report("unexpected beat", 64'(got.status), '0);
            return;
         end
         w = pending.pop_front();
         if (got.status != w.status) report("status", 64'(got.status), 64'(w.status));
         if (got.removed_tag != w.removed_tag)
            report("removed_tag", 64'(got.removed_tag), 64'(w.removed_tag));
         if (got.removed_time != w.removed_time)
            report("removed_time", 64'(got.removed_time), 64'(w.removed_time));
         if (got.entry_count != w.entry_count)
            report("entry_count", 64'(got.entry_count), 64'(w.entry_count));
         if (got.top_valid != w.top_valid)
            report("top_valid", 64'(got.top_valid), 64'(w.top_valid));
         if (got.top_tag != w.top_tag) report("top_tag", 64'(got.top_tag), 64'(w.top_tag));
         if (got.top_time != w.top_time)
            report("top_time", 64'(got.top_time), 64'(w.top_time));
      endtask
   endclass

   event_queue_scoreboard queue_model = new();

   sorted_timer_event_queue_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout waiting for the queue");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_op(input kind_type kind, input logic [TAG_BITS-1:0] tag,
                          input logic [TIME_BITS-1:0] tim);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= IN_W'({tim, tag});
      do @(posedge clock); while (!req_tready);
      queue_model.apply(kind, tag, tim);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (queue_model.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [TIME_BITS-1:0] rand_time();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return TIME_BITS'($urandom_range(0, 7));
         default: return TIME_BITS'($urandom);
      endcase
   endfunction

   // Tags are drawn from a small pool most of the time so restart and cancel usually hit.
   function automatic logic [TAG_BITS-1:0] rand_tag();
      if ($urandom_range(0, 9) == 0) return TAG_BITS'($urandom);
      return TAG_BITS'($urandom_range(0, 23));
   endfunction

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) queue_model.check(result_type'(rsp_tdata[OUT_BITS-1:0]));
   end

   initial begin
      int gap;
      bit long_taken;
      long_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_taken) begin
            rsp_tready <= 1'b0;
            hold_cycles <= 200;
            long_taken = 1'b1;
         end else if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
         end else if (rsp_tready && rsp_tvalid) begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               hold_cycles <= gap - 1;
            end
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int i;
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_op(KIND_POP, 8'd0, 32'd0);
      send_op(KIND_CANCEL, 8'd5, 32'd0);
      send_op(KIND_RESTART, 8'd5, 32'd9);
      for (i = 0; i < DEPTH; i++)
         send_op(KIND_INSERT, (i == 3) ? 8'hff : 8'(i), (i % 3 == 0) ? 32'hffffffff : 32'(i % 3));
      send_op(KIND_INSERT, 8'd99, 32'd0);
      send_op(KIND_RESTART, 8'd1, 32'd1);
      send_op(KIND_RESTART, 8'd2, 32'd0);
      send_op(KIND_RESTART, 8'd0, 32'd1);
      send_op(KIND_CANCEL, 8'hff, 32'd0);
      send_op(KIND_INSERT, 8'd1, 32'd0);
      send_op(KIND_CANCEL, 8'd1, 32'd0);
      send_op(KIND_POP, 8'd0, 32'd0);
      wait_drained();

      long_hold_req = 1'b1;
      for (i = 0; i < 8; i++) send_op(KIND_POP, 8'd0, 32'd0);

      for (i = 0; i < N_RANDOM; i++) begin
         k = $urandom_range(0, 99);
         if (i == N_RANDOM / 2) wait_drained();
         if (k < 35) send_op(KIND_INSERT, rand_tag(), rand_time());
         else if (k < 60) send_op(KIND_POP, TAG_BITS'($urandom), TIME_BITS'($urandom));
         else if (k < 80) send_op(KIND_RESTART, rand_tag(), rand_time());
         else send_op(KIND_CANCEL, rand_tag(), TIME_BITS'($urandom));
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("ops insert/pop/restart/cancel: %0d %0d %0d %0d",
               queue_model.n_ops[0], queue_model.n_ops[1], queue_model.n_ops[2],
               queue_model.n_ops[3]);
      $display("status ok/empty/full/not found: %0d %0d %0d %0d",
               queue_model.n_status[0], queue_model.n_status[1], queue_model.n_status[2],
               queue_model.n_status[3]);
      if (error_count == 0 && queue_model.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/stq_pkg.sv
rtl/stq_datapath.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_event_queue_core.sv
dv/tb.sv
